// ----- hdl/ess_pkg.sv -----
// Shared types, codes and constants of the escape sequence splitter.
package ess_pkg;

  localparam logic [15:0] MaxTextLen = 16'd65535;

  localparam logic [15:0] ChEsc      = 16'h001b;
  localparam logic [15:0] ChParOpen  = 16'h0028;
  localparam logic [15:0] ChSqOpen   = 16'h005b;
  localparam logic [15:0] ChBrOpen   = 16'h007b;
  localparam logic [15:0] ChAngOpen  = 16'h003c;
  localparam logic [15:0] ChTail     = 16'h0054;
  localparam logic [7:0]  ChParClose = 8'h29;
  localparam logic [7:0]  ChSqClose  = 8'h5d;
  localparam logic [7:0]  ChBrClose  = 8'h7d;
  localparam logic [7:0]  ChAngClose = 8'h3e;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KindPlain  = 2'd0,
    KindEscape = 2'd1,
    KindEcho   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ModePlain   = 2'd0,
    ModeSelect  = 2'd1,
    ModeBracket = 2'd2,
    ModeTail    = 2'd3
  } mode_e;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] range_begin;
    logic [15:0] range_end;
    logic [15:0] plain_unit;
    logic        overflow;
    logic        last_result;
  } out_item_t;

  // Results caused by one code unit; first is always valid when queued.
  typedef struct packed {
    logic      two;
    out_item_t first;
    out_item_t second;
  } entry_t;

  function automatic out_item_t mk_item(kind_e k, logic [15:0] b, logic [15:0] e,
                                        logic [15:0] u, logic ovf);
    out_item_t r;
    r.kind        = k;
    r.range_begin = b;
    r.range_end   = e;
    r.plain_unit  = u;
    r.overflow    = ovf;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

// ----- hdl/ess_front.sv -----
// Front end: scan state machine that classifies each code unit into result entries.
module ess_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ess_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output ess_pkg::entry_t   q_entry_o
);
  import ess_pkg::*;

  mode_e       mode_q, mode_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  closer_q, closer_d;
  logic [15:0] pstart_q, pstart_d;
  logic [15:0] estart_q, estart_d;
  logic        ovf_q, ovf_d;

  logic        accept;
  logic        have_first;
  logic        ovf_hit;
  logic        ovf_now;
  logic [15:0] p;
  logic [15:0] nxt;
  logic [15:0] u;
  entry_t      ent;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && have_first;
  assign q_entry_o  = ent;

  always_comb begin
    u       = in_item_i.code_unit;
    p       = pos_q;
    ovf_hit = (p >= MaxTextLen);
    ovf_now = ovf_q || ovf_hit;
    nxt     = ovf_hit ? MaxTextLen : p + 16'd1;

    mode_d     = mode_q;
    pos_d      = pos_q;
    closer_d   = closer_q;
    pstart_d   = pstart_q;
    estart_d   = estart_q;
    ovf_d      = ovf_now;
    have_first = 1'b0;
    ent        = '0;

    unique case (mode_q)
      ModePlain: begin
        if (u == ChEsc) begin
          if (pstart_q < p) begin
            have_first = 1'b1;
            ent.first  = mk_item(KindPlain, pstart_q, p, 16'd0, ovf_now);
          end
          estart_d = nxt;
          mode_d   = ModeSelect;
          if (in_item_i.last_unit) begin
            if (have_first) begin
              ent.two    = 1'b1;
              ent.second = mk_item(KindEscape, nxt, nxt, 16'd0, ovf_now);
            end else begin
              have_first = 1'b1;
              ent.first  = mk_item(KindEscape, nxt, nxt, 16'd0, ovf_now);
            end
          end
        end else begin
          have_first = 1'b1;
          ent.first  = mk_item(KindEcho, 16'd0, 16'd0, u, ovf_now);
          if (in_item_i.last_unit) begin
            ent.two    = 1'b1;
            ent.second = mk_item(KindPlain, pstart_q, nxt, 16'd0, ovf_now);
          end
        end
      end
      ModeSelect: begin
        if (u == ChParOpen || u == ChSqOpen || u == ChBrOpen || u == ChAngOpen) begin
          closer_d = (u == ChParOpen) ? ChParClose :
                     (u == ChSqOpen)  ? ChSqClose  :
                     (u == ChBrOpen)  ? ChBrClose  : ChAngClose;
          mode_d   = ModeBracket;
          if (in_item_i.last_unit) begin
            have_first = 1'b1;
            ent.first  = mk_item(KindEscape, estart_q, nxt, 16'd0, ovf_now);
          end
        end else if (u == ChTail) begin
          mode_d = ModeTail;
          if (in_item_i.last_unit) begin
            have_first = 1'b1;
            ent.first  = mk_item(KindEscape, estart_q, nxt, 16'd0, ovf_now);
          end
        end else begin
          have_first = 1'b1;
          ent.first  = mk_item(KindEscape, estart_q, nxt, 16'd0, ovf_now);
          mode_d     = ModePlain;
          pstart_d   = nxt;
        end
      end
      ModeBracket: begin
        if (u == {8'd0, closer_q}) begin
          have_first = 1'b1;
          ent.first  = mk_item(KindEscape, estart_q, nxt, 16'd0, ovf_now);
          mode_d     = ModePlain;
          pstart_d   = nxt;
        end else if (in_item_i.last_unit) begin
          have_first = 1'b1;
          ent.first  = mk_item(KindEscape, estart_q, nxt, 16'd0, ovf_now);
        end
      end
      ModeTail: begin
        have_first = 1'b1;
        ent.first  = mk_item(KindEscape, estart_q, nxt, 16'd0, ovf_now);
        mode_d     = ModePlain;
        pstart_d   = nxt;
      end
      default: begin
        mode_d = ModePlain;
      end
    endcase

    if (ent.two) begin
      ent.second.last_result = 1'b1;
    end else begin
      ent.first.last_result = 1'b1;
    end

    if (in_item_i.last_unit) begin
      mode_d   = ModePlain;
      pos_d    = 16'd0;
      closer_d = 8'd0;
      pstart_d = 16'd0;
      estart_d = 16'd0;
      ovf_d    = 1'b0;
    end else begin
      pos_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModePlain;
      pos_q    <= 16'd0;
      closer_q <= 8'd0;
      pstart_q <= 16'd0;
      estart_q <= 16'd0;
      ovf_q    <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      closer_q <= closer_d;
      pstart_q <= pstart_d;
      estart_q <= estart_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// ----- hdl/ess_queue.sv -----
// Short result-entry queue between the front and back ends.
module ess_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ess_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ess_pkg::entry_t pop_entry_o
);
  import ess_pkg::*;

  entry_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, wr_d;
  logic [QueuePtrW-1:0]   rd_q, rd_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o     = (cnt_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && !empty_o;
  assign pop_entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/ess_back.sv -----
// Back end: output register that delivers the results of each entry in order.
module ess_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  ess_pkg::entry_t    q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ess_pkg::out_item_t out_item_o
);
  import ess_pkg::*;

  entry_t cur_q;
  logic   sel_q;
  logic   valid_q;
  logic   xfer;
  logic   done;
  logic   load;

  assign xfer        = valid_q && out_ready_i;
  assign done        = xfer && (sel_q || !cur_q.two);
  assign load        = !valid_q || done;
  assign q_pop_o     = load && !q_empty_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = sel_q ? cur_q.second : cur_q.first;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (load) begin
      valid_q <= !q_empty_i;
      sel_q   <= 1'b0;
    end else if (xfer) begin
      sel_q <= 1'b1;
    end
  end

endmodule

// ----- hdl/escape_sequence_splitter_unit.sv -----
// Top level of the escape sequence splitter: front end, entry queue, back end.
// The first result of a code unit passes through the entry queue and then the output register
// before its earliest transaction.
// Throughput: one code unit per cycle while the entry queue is not full; a unit causing two results
// holds the output port for both of them, and the four-entry queue absorbs the difference.
// Reset: rst_ni clears scan state, queue and output register asynchronously.
module escape_sequence_splitter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ess_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ess_pkg::out_item_t out_item_o
);
  import ess_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_empty;
  entry_t push_entry;
  entry_t pop_entry;

  ess_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  ess_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .pop_entry_o  (pop_entry)
  );

  ess_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- hdl/ess_checker.sv -----
// Port-level checker for the escape sequence splitter, bound to the top level.
module ess_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input ess_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ess_pkg::out_item_t out_item_o
);
  import ess_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result transaction changed");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KindEcho |->
      out_item_o.range_begin == 16'd0 && out_item_o.range_end == 16'd0)
    else $error("echo carries a range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KindEcho |->
      out_item_o.plain_unit == 16'd0 && out_item_o.range_begin <= out_item_o.range_end)
    else $error("malformed range result");

endmodule

bind escape_sequence_splitter_unit ess_checker u_ess_checker (.*);

// ----- bench/tb_escape_sequence_splitter_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the escape sequence splitter against a predictor of its ranges.
module tb_escape_sequence_splitter_unit;
  import ess_pkg::*;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  escape_sequence_splitter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor state
  logic [15:0] sc_pos;
  logic [15:0] sc_plain_start;
  logic [15:0] sc_esc_start;
  logic [7:0]  sc_closer;
  mode_e       sc_mode;
  logic        sc_ovf;

  in_item_t    pending_units[$];
  out_item_t   expected_splits[$];
  logic [15:0] text_buf[$];

  int  error_count  = 0;
  int  text_count   = 0;
  int  unit_count   = 0;
  int  results_seen = 0;
  int  in_gap       = 0;
  int  out_gap      = 0;
  bit  in_calm      = 1'b0;
  bit  out_calm     = 1'b0;
  bit  idle_on      = 1'b1;

  function automatic void reset_scan();
    sc_pos         = '0;
    sc_plain_start = '0;
    sc_esc_start   = '0;
    sc_closer      = '0;
    sc_mode        = ModePlain;
    sc_ovf         = 1'b0;
  endfunction

  function automatic out_item_t split_result(kind_e k, logic [15:0] b, logic [15:0] e,
                                             logic [15:0] u);
    out_item_t r;
    r.kind        = k;
    r.range_begin = b;
    r.range_end   = e;
    r.plain_unit  = u;
    r.overflow    = sc_ovf;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic void predict_splits(in_item_t it);
    logic [15:0] u;
    logic [15:0] p;
    logic [15:0] nxt;
    logic [16:0] wide;
    logic        fin;
    out_item_t   batch[$];
    u    = it.code_unit;
    fin  = it.last_unit;
    p    = sc_pos;
    if (p >= MaxTextLen) sc_ovf = 1'b1;
    wide = {1'b0, p} + 17'd1;
    nxt  = (wide > {1'b0, MaxTextLen}) ? MaxTextLen : wide[15:0];
    case (sc_mode)
      ModePlain: begin
        if (u == ChEsc) begin
          if (sc_plain_start < p) batch.push_back(split_result(KindPlain, sc_plain_start, p, '0));
          sc_esc_start = nxt;
          sc_mode      = ModeSelect;
          if (fin) batch.push_back(split_result(KindEscape, nxt, nxt, '0));
        end else begin
          batch.push_back(split_result(KindEcho, '0, '0, u));
          if (fin) batch.push_back(split_result(KindPlain, sc_plain_start, nxt, '0));
        end
      end
      ModeSelect: begin
        if (u == ChParOpen || u == ChSqOpen || u == ChBrOpen || u == ChAngOpen) begin
          sc_closer = (u == ChParOpen) ? ChParClose : (u == ChSqOpen) ? ChSqClose :
                      (u == ChBrOpen) ? ChBrClose : ChAngClose;
          sc_mode   = ModeBracket;
          if (fin) batch.push_back(split_result(KindEscape, sc_esc_start, nxt, '0));
        end else if (u == ChTail) begin
          sc_mode = ModeTail;
          if (fin) batch.push_back(split_result(KindEscape, sc_esc_start, nxt, '0));
        end else begin
          batch.push_back(split_result(KindEscape, sc_esc_start, nxt, '0));
          sc_mode        = ModePlain;
          sc_plain_start = nxt;
        end
      end
      ModeBracket: begin
        if (u == {8'h00, sc_closer}) begin
          batch.push_back(split_result(KindEscape, sc_esc_start, nxt, '0));
          sc_mode        = ModePlain;
          sc_plain_start = nxt;
        end else if (fin) begin
          batch.push_back(split_result(KindEscape, sc_esc_start, nxt, '0));
        end
      end
      default: begin
        batch.push_back(split_result(KindEscape, sc_esc_start, nxt, '0));
        sc_mode        = ModePlain;
        sc_plain_start = nxt;
      end
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last_result = 1'b1;
    foreach (batch[i]) expected_splits.push_back(batch[i]);
    if (fin) reset_scan();
    else sc_pos = nxt;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_split(input out_item_t got, input out_item_t want);
    if (got.kind !== want.kind)
      report_error($sformatf("kind got %0d want %0d", got.kind, want.kind));
    if (got.range_begin !== want.range_begin)
      report_error($sformatf("range_begin got %0d want %0d", got.range_begin, want.range_begin));
    if (got.range_end !== want.range_end)
      report_error($sformatf("range_end got %0d want %0d", got.range_end, want.range_end));
    if (got.plain_unit !== want.plain_unit)
      report_error($sformatf("plain_unit got %0h want %0h", got.plain_unit, want.plain_unit));
    if (got.overflow !== want.overflow)
      report_error($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
    if (got.last_result !== want.last_result)
      report_error($sformatf("last_result got %0b want %0b", got.last_result, want.last_result));
  endtask

  // moves text_buf into the pending queue as one text
  task automatic push_text();
    in_item_t it;
    foreach (text_buf[i]) begin
      it.code_unit = text_buf[i];
      it.last_unit = (i == text_buf.size() - 1);
      pending_units.push_back(it);
    end
    unit_count += text_buf.size();
    text_count++;
    text_buf.delete();
  endtask

  function automatic logic [15:0] rand_plain();
    logic [15:0] u;
    u = 16'($urandom);
    return (u == ChEsc) ? 16'h0020 : u;
  endfunction

  function automatic logic [15:0] opener_of(int idx);
    case (idx)
      0:       return ChParOpen;
      1:       return ChSqOpen;
      2:       return ChBrOpen;
      default: return ChAngOpen;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(int idx);
    case (idx)
      0:       return ChParClose;
      1:       return ChSqClose;
      2:       return ChBrClose;
      default: return ChAngClose;
    endcase
  endfunction

  task automatic gen_text();
    int          segs;
    int          sel;
    int          len;
    int          br;
    int          cut;
    logic [15:0] op;
    logic [7:0]  cl;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        3, 4: begin
          br = $urandom_range(0, 3);
          text_buf.push_back(ChEsc);
          text_buf.push_back(opener_of(br));
          len = $urandom_range(0, 4);
          for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 4))
              0: text_buf.push_back(16'($urandom));
              1: text_buf.push_back(ChEsc);
              2: text_buf.push_back({8'h00, closer_of($urandom_range(0, 3))});
              3: begin
                cl = closer_of(br);
                text_buf.push_back({8'($urandom_range(1, 255)), cl});
              end
              default: text_buf.push_back(rand_plain());
            endcase
          end
          if ($urandom_range(0, 7) != 0) text_buf.push_back({8'h00, closer_of(br)});
        end
        5: begin
          text_buf.push_back(ChEsc);
          text_buf.push_back(ChTail);
          text_buf.push_back(($urandom_range(0, 3) == 0) ? ChEsc : 16'($urandom));
        end
        6: begin
          text_buf.push_back(ChEsc);
          text_buf.push_back(($urandom_range(0, 3) == 0) ? ChEsc : 16'($urandom));
        end
        7: begin
          op = ($urandom_range(0, 4) == 0) ? ChTail : opener_of($urandom_range(0, 3));
          text_buf.push_back(ChEsc);
          text_buf.push_back({8'($urandom_range(1, 255)), op[7:0]});
        end
        8: begin
          len = $urandom_range(1, 3);
          for (int k = 0; k < len; k++)
            text_buf.push_back(($urandom_range(0, 3) == 0) ? ChEsc : 16'($urandom));
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int k = 0; k < len; k++) text_buf.push_back(rand_plain());
        end
      endcase
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, text_buf.size());
      while (text_buf.size() > cut) void'(text_buf.pop_back());
    end
    push_text();
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_splits(in_item_i);
      if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
      if (!in_valid_i || in_ready_o) begin
        if (in_gap == 0 && idle_on && !in_calm && $urandom_range(0, 9) == 0)
          in_gap = $urandom_range(1, 19);
        if (in_gap > 0 && idle_on) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_units.size() > 0) begin
          in_item_i  <= pending_units.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_splits.size() == 0) report_error("transaction with no result expected");
        else check_split(out_item_o, expected_splits.pop_front());
      end
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (out_gap == 0 && idle_on && !out_calm && $urandom_range(0, 9) == 0)
        out_gap = $urandom_range(1, 19);
      if (out_gap > 0 && idle_on) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int directed_units;
    rst_ni = 1'b0;
    reset_scan();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, every selector, ESC inside brackets, wide selectors
    text_buf = '{16'h0000, 16'hffff, ChEsc, ChParOpen, ChEsc, {8'h00, ChParClose},
                 ChEsc, ChTail, 16'h005a, ChEsc, 16'h015b, ChEsc, ChBrOpen,
                 {8'h01, ChBrClose}, {8'h00, ChBrClose}, ChEsc, ChAngOpen,
                 {8'h00, ChAngClose}, ChEsc, ChSqOpen, {8'h00, ChSqClose}, 16'h7a7a};
    push_text();
    text_buf = '{ChEsc};
    push_text();
    text_buf = '{ChEsc, ChSqOpen, 16'h0061};
    push_text();
    text_buf = '{ChEsc, ChTail};
    push_text();
    directed_units = unit_count;

    while (unit_count < directed_units + 800) gen_text();

    while (pending_units.size() != 0 || in_valid_i || expected_splits.size() != 0)
      @(negedge clk_i);

    // final part without idling: one mixed text ending in an unclosed bracket
    idle_on = 1'b0;
    for (int i = 0; i < 12; i++) text_buf.push_back(rand_plain());
    text_buf.push_back(ChEsc);
    text_buf.push_back(ChSqOpen);
    text_buf.push_back(16'h0078);
    text_buf.push_back({8'h00, ChSqClose});
    text_buf.push_back(rand_plain());
    text_buf.push_back(rand_plain());
    text_buf.push_back(ChEsc);
    text_buf.push_back(ChTail);
    text_buf.push_back(16'h0071);
    text_buf.push_back(rand_plain());
    text_buf.push_back(ChEsc);
    text_buf.push_back(ChParOpen);
    text_buf.push_back(rand_plain());
    push_text();

    while (pending_units.size() != 0 || in_valid_i || expected_splits.size() != 0)
      @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (expected_splits.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_splits.size()));

    $display("covered %0d texts, %0d code units, %0d results checked, %0d mismatches",
             text_count, unit_count, results_seen, error_count);
    $display("random escapes, cut-off texts and a stall-free closing text");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
